/* hdl/bppr_pkg.sv */
// bppr_pkg: shared types, constants and byte helpers for the bounded path prefix replacer
// no dependencies; used by bppr_cfg, bounded_path_prefix_replacer and bppr_chk
package bppr_pkg;

  localparam int MAX_PATTERN = 24;
  localparam int LEN_W       = 5;   // holds 0..MAX_PATTERN + 1
  localparam int BYTE_W      = 8;
  localparam int PTR_W       = 5;   // circular window pointer
  localparam int WIN_DEPTH   = 32;  // 2**PTR_W, covers MAX_PATTERN + 1 pending bytes
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int BANK_WORDS  = 3;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_LOW   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_MID   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_HIGH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES_LOW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES_MID   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES_HIGH  = 4'd7;

  // boundary characters
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;

  typedef logic [BANK_WORDS-1:0][CFG_DATA_W-1:0] byte_bank_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } out_item_t;

  // effective configuration as seen by the sequencer
  typedef struct packed {
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rep_len;
    logic [BYTE_W-1:0] pat_byte;
    logic [BYTE_W-1:0] rep_byte;
    logic              plen_write;
  } cfg_view_t;

  function automatic logic is_boundary(input logic [BYTE_W-1:0] b);
    return (b == CH_SLASH) || (b == CH_DQUOTE) || (b == CH_SQUOTE);
  endfunction

  // byte k of a three-word bank, word index wraps modulo three
  function automatic logic [BYTE_W-1:0] byte_of(input byte_bank_t bank,
                                                input logic [LEN_W-1:0] k);
    logic [1:0] w;
    w = (k[4:3] == 2'd3) ? 2'd0 : k[4:3];
    return bank[w][{k[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

/* hdl/bounded_path_prefix_replacer.sv */
// bounded_path_prefix_replacer: streaming find and replace on a byte stream
// depends on bppr_pkg and bppr_cfg
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   src     | in        | src_valid/src_stall| in_item_t  {data_byte, is_last}
//   dst     | out       | dst_valid/dst_stall| out_item_t {out_byte, out_last}
//   cfg     | in        | cfg_valid/cfg_ready| cfg_index (register), cfg_data
//
// one byte is taken per transfer, then the block is busy until that byte's
// work is done: a window check walks the pattern one byte at a time through
// the single read port of the window memory (S_RD, then S_CMP), then emits the
// replacement or the oldest window byte. a byte that fills no window goes from
// S_DECIDE straight to S_FLUSH; the final byte adds the drain of the window.
// rst is synchronous and clears the sequencer, fill count and output register;
// the window memory is never cleared. a stalled dst holds the output register,
// and the sequencer waits while a pending byte cannot move.
module bounded_path_prefix_replacer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            src_stall,
  input  bppr_pkg::in_item_t              src_data,
  output logic                            dst_valid,
  input  logic                            dst_stall,
  output bppr_pkg::out_item_t             dst_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bppr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bppr_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,  // waiting for a byte
    S_DECIDE = 8'b0000_0010,  // pick check, drain step or step end
    S_RD     = 8'b0000_0100,  // window read in flight
    S_CMP    = 8'b0000_1000,  // compare one window byte
    S_REP    = 8'b0001_0000,  // emit replacement bytes
    S_E_RD   = 8'b0010_0000,  // read oldest window byte
    S_E_OUT  = 8'b0100_0000,  // emit oldest window byte
    S_FLUSH  = 8'b1000_0000   // push the held byte, closing the step
  } state_t;

  state_t                       state, state_next;
  logic [bppr_pkg::LEN_W-1:0]   fill, fill_next;       // pending bytes
  logic [bppr_pkg::PTR_W-1:0]   head, head_next;       // oldest pending byte
  logic [bppr_pkg::LEN_W-1:0]   idx, idx_next;         // compare position
  logic [bppr_pkg::LEN_W-1:0]   rcnt, rcnt_next;       // replacement position
  logic                         last_flag, last_flag_next;
  logic                         main_mode, main_mode_next;
  logic [bppr_pkg::BYTE_W-1:0]  pend_byte, pend_byte_next;
  logic                         pend_valid, pend_valid_next;
  logic                         dst_valid_next;
  bppr_pkg::out_item_t          dst_data_next;

  logic [bppr_pkg::BYTE_W-1:0]  win_mem [bppr_pkg::WIN_DEPTH];
  logic [bppr_pkg::BYTE_W-1:0]  rd_data;
  logic [bppr_pkg::PTR_W-1:0]   rd_addr;
  logic [bppr_pkg::PTR_W-1:0]   wr_addr;
  logic                         mem_we;

  bppr_pkg::cfg_view_t          view;
  logic [bppr_pkg::LEN_W-1:0]   plen_inc;

  // held-byte path: each new byte pushes the previous one out, so the very
  // last byte of a step can still be tagged at step end
  logic                         prod_req;
  logic                         prod_ok;
  logic [bppr_pkg::BYTE_W-1:0]  prod_byte;
  logic                         out_free;

  bppr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_idx   (idx),
    .rep_idx   (rcnt),
    .view      (view)
  );

  assign cfg_ready = 1'b1;
  assign src_stall = (state != S_IDLE);
  assign plen_inc  = view.plen + bppr_pkg::LEN_W'(1);
  assign out_free  = !dst_valid || !dst_stall;
  assign prod_ok   = !pend_valid || out_free;
  assign rd_addr   = head + bppr_pkg::PTR_W'(idx);
  assign wr_addr   = head + bppr_pkg::PTR_W'(fill);

  // window memory, circular, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wr_addr] <= src_data.data_byte;
    end
    rd_data <= win_mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    head_next       = head;
    idx_next        = idx;
    rcnt_next       = rcnt;
    last_flag_next  = last_flag;
    main_mode_next  = main_mode;
    pend_byte_next  = pend_byte;
    pend_valid_next = pend_valid;
    dst_valid_next  = dst_stall ? dst_valid : 1'b0;
    dst_data_next   = dst_data;
    mem_we          = 1'b0;
    prod_req        = 1'b0;
    prod_byte       = rd_data;

    case (state)
      S_IDLE: begin
        if (src_valid) begin
          mem_we         = 1'b1;
          fill_next      = fill + bppr_pkg::LEN_W'(1);
          last_flag_next = src_data.is_last;
          state_next     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_next = '0;
        if (fill == plen_inc) begin
          // full window: pattern plus boundary byte
          main_mode_next = 1'b1;
          state_next     = S_RD;
        end else if (last_flag && (fill != '0)) begin
          // drain step: only a whole-window pattern can still match
          main_mode_next = 1'b0;
          state_next     = (fill == view.plen) ? S_RD : S_E_RD;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (idx == view.plen) begin
          // byte after the pattern
          if (bppr_pkg::is_boundary(rd_data)) begin
            rcnt_next  = '0;
            state_next = S_REP;
          end else begin
            idx_next   = '0;
            state_next = S_E_RD;
          end
        end else if (rd_data != view.pat_byte) begin
          idx_next   = '0;
          state_next = S_E_RD;
        end else if (idx == view.plen - bppr_pkg::LEN_W'(1)) begin
          if (main_mode) begin
            idx_next   = view.plen;
            state_next = S_RD;
          end else begin
            rcnt_next  = '0;
            state_next = S_REP;
          end
        end else begin
          idx_next   = idx + bppr_pkg::LEN_W'(1);
          state_next = S_RD;
        end
      end
      S_REP: begin
        if (rcnt == view.rep_len) begin
          head_next  = head + bppr_pkg::PTR_W'(view.plen);
          fill_next  = fill - view.plen;
          state_next = S_DECIDE;
        end else begin
          prod_req  = 1'b1;
          prod_byte = view.rep_byte;
          if (prod_ok) begin
            rcnt_next = rcnt + bppr_pkg::LEN_W'(1);
          end
        end
      end
      S_E_RD: begin
        state_next = S_E_OUT;
      end
      S_E_OUT: begin
        prod_req = 1'b1;
        if (prod_ok) begin
          head_next  = head + bppr_pkg::PTR_W'(1);
          fill_next  = fill - bppr_pkg::LEN_W'(1);
          state_next = S_DECIDE;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          dst_valid_next         = 1'b1;
          dst_data_next.out_byte = pend_byte;
          dst_data_next.out_last = last_flag;
          pend_valid_next        = 1'b0;
          state_next             = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // new byte goes to the hold register, the held one moves to the output
    if (prod_req && prod_ok) begin
      if (pend_valid) begin
        dst_valid_next         = 1'b1;
        dst_data_next.out_byte = pend_byte;
        dst_data_next.out_last = 1'b0;
      end
      pend_byte_next  = prod_byte;
      pend_valid_next = 1'b1;
    end

    // a new pattern length discards the pending window
    if (view.plen_write) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      head       <= '0;
      idx        <= '0;
      rcnt       <= '0;
      last_flag  <= 1'b0;
      main_mode  <= 1'b0;
      pend_valid <= 1'b0;
      dst_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      head       <= head_next;
      idx        <= idx_next;
      rcnt       <= rcnt_next;
      last_flag  <= last_flag_next;
      main_mode  <= main_mode_next;
      pend_valid <= pend_valid_next;
      dst_valid  <= dst_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    dst_data  <= dst_data_next;
  end

endmodule

/* hdl/bppr_cfg.sv */
// bppr_cfg: configuration registers, length clamping and pattern/replacement byte select
// depends on bppr_pkg
module bppr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [bppr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bppr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [bppr_pkg::LEN_W-1:0]         pat_idx,
  input  logic [bppr_pkg::LEN_W-1:0]         rep_idx,
  output bppr_pkg::cfg_view_t                view
);

  logic [bppr_pkg::LEN_W-1:0] pattern_length;
  logic [bppr_pkg::LEN_W-1:0] replacement_length;
  bppr_pkg::byte_bank_t       pat_bank;
  bppr_pkg::byte_bank_t       rep_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= bppr_pkg::LEN_W'(1);
      replacement_length <= '0;
      pat_bank           <= '0;
      rep_bank           <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bppr_pkg::REG_PATTERN_LENGTH:     pattern_length <= cfg_data[bppr_pkg::LEN_W-1:0];
        bppr_pkg::REG_PATTERN_BYTES_LOW:  pat_bank[0] <= cfg_data;
        bppr_pkg::REG_PATTERN_BYTES_MID:  pat_bank[1] <= cfg_data;
        bppr_pkg::REG_PATTERN_BYTES_HIGH: pat_bank[2] <= cfg_data;
        bppr_pkg::REG_REPLACE_LENGTH:     replacement_length <= cfg_data[bppr_pkg::LEN_W-1:0];
        bppr_pkg::REG_REPLACE_BYTES_LOW:  rep_bank[0] <= cfg_data;
        bppr_pkg::REG_REPLACE_BYTES_MID:  rep_bank[1] <= cfg_data;
        bppr_pkg::REG_REPLACE_BYTES_HIGH: rep_bank[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      view.plen = bppr_pkg::LEN_W'(1);
    end else if (pattern_length > bppr_pkg::MAX_LEN) begin
      view.plen = bppr_pkg::MAX_LEN;
    end else begin
      view.plen = pattern_length;
    end
    view.rep_len    = (replacement_length > bppr_pkg::MAX_LEN) ? bppr_pkg::MAX_LEN
                                                               : replacement_length;
    view.pat_byte   = bppr_pkg::byte_of(pat_bank, pat_idx);
    view.rep_byte   = bppr_pkg::byte_of(rep_bank, rep_idx);
    view.plen_write = cfg_valid && (cfg_index == bppr_pkg::REG_PATTERN_LENGTH);
  end

endmodule

/* hdl/bppr_chk.sv */
// bppr_chk: port-level checks for bounded_path_prefix_replacer, attached by bind
// depends on bppr_pkg
module bppr_chk (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input bppr_pkg::in_item_t  src_data,
  input logic                dst_valid,
  input logic                dst_stall,
  input bppr_pkg::out_item_t dst_data
);

  // a stalled result holds
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("stalled output changed");

  // a stalled input byte holds
  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_data))
    else $error("stalled input changed");

  // the block is busy right after taking a byte
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    src_valid && !src_stall |=> src_stall)
    else $error("input taken twice in a row");

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("output valid after reset");

  // new results only come from work in progress
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(dst_valid) |-> $past(src_stall))
    else $error("output appeared while idle");

endmodule

bind bounded_path_prefix_replacer bppr_chk u_bppr_chk (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_data  (src_data),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_data  (dst_data)
);
